// ----- rtl/mobius_sieve_coprime_counter_macros.svh -----
// Assertion helpers for the top-level RTL. All are clocked on clk and off in reset.
`ifndef MOBIUS_SIEVE_COPRIME_COUNTER_MACROS_SVH
`define MOBIUS_SIEVE_COPRIME_COUNTER_MACROS_SVH

// same-cycle implication
`define MSC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msc assertion failed");

// next-cycle implication
`define MSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msc assertion failed");

`endif

// ----- rtl/msc_pkg.sv -----
package msc_pkg;

    localparam int SIDE_W  = 17;
    localparam int CFG_W   = 17;
    localparam int CNT_W   = 33;
    localparam int MERT_W  = 16;
    localparam int ACC_W   = 56;

    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_BUILT = 2'd1;
    localparam logic [1:0] ST_OVER      = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [SIDE_W-1:0] side_a;
        logic [SIDE_W-1:0] side_b;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0] visible_count;
        logic [1:0]       status;
    } rsp_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_CLR, S_INIT0, S_INIT1, S_SV_RD, S_SV_CHK,
        S_IN_TEST, S_IN_P, S_IN_MARK, S_SV_NEXT, S_PF_RD, S_PF_WR, S_FIN_B,
        S_Q_CHK, S_DIV_GO, S_DIV_WAIT, S_Q_RD, S_Q_MUL1, S_Q_MUL2, S_Q_ACC,
        S_Q_FIN, S_RESP
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CLR, OP_INIT0, OP_INIT1, OP_SV_RD, OP_SV_CHK,
        OP_IN_RD, OP_IN_P, OP_IN_MARK, OP_SV_NEXT, OP_PF_RD, OP_PF_WR,
        OP_FIN_B, OP_Q_CHK, OP_DIV_GO, OP_DIV_WAIT, OP_Q_RD, OP_Q_MUL1,
        OP_Q_MUL2, OP_Q_ACC, OP_FIN_Q
    } dp_op_t;

    typedef struct packed {
        logic is_query;
        logic clr_last;
        logic i_last;
        logic j_end;
        logic prod_over;
        logic p_is_lpf;
        logic div_done;
        logic dph_last;
        logic blk_last;
        logic q_special;
    } dp_stat_t;

endpackage

// ----- rtl/msc_div.sv -----
module msc_div #(
    parameter int W = 17
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quo
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  den_reg;
    logic [W:0]    shifted;
    logic [W:0]    trial;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (trial[W])
            begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
            else
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- rtl/msc_dp.sv -----
module msc_dp #(
    parameter int MAX_N      = 65536,
    parameter int MAX_PRIMES = 8192
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  msc_pkg::dp_op_t            op,
    input  msc_pkg::req_t              req,
    input  logic                       cfg_we,
    input  logic [msc_pkg::CFG_W-1:0]  cfg_data,
    output msc_pkg::dp_stat_t          stat,
    output msc_pkg::rsp_t              rsp
);

    localparam int SW   = msc_pkg::SIDE_W;
    localparam int NW   = $clog2(MAX_N + 1);
    localparam int CW   = (NW > SW) ? NW : SW;
    localparam int PW   = $clog2(MAX_PRIMES + 1);
    localparam int PAW  = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
    localparam int MW   = msc_pkg::MERT_W;
    localparam int AW   = msc_pkg::ACC_W;
    localparam int QW   = 2 * SW;
    localparam int TW   = MW + 1 + QW + 1;
    localparam int NDEP = MAX_N + 1;

    logic [MW-1:0] mert_mem [NDEP];
    logic [NW-1:0] lpf_mem  [NDEP];
    logic [NW-1:0] prime_mem [MAX_PRIMES];

    logic [msc_pkg::CFG_W-1:0] sieve_limit_reg;
    logic [NW-1:0]  lim_reg;
    logic [NW-1:0]  built_reg;
    logic           cmd_reg;
    logic [NW-1:0]  c_reg;
    logic [NW-1:0]  i_reg;
    logic [PW-1:0]  j_reg;
    logic [PW-1:0]  pc_reg;
    logic [MW-1:0]  mu_reg;
    logic [NW-1:0]  lpfi_reg;
    logic [NW-1:0]  p_reg;
    logic [2*NW-1:0] prod_reg;
    logic [MW-1:0]  macc_reg;
    logic [SW-1:0]  a_reg, b_reg, m_reg, n_reg, l_reg;
    logic [SW-1:0]  qm_reg, qn_reg, rm_reg, r_reg;
    logic [1:0]     dph_reg;
    logic [MW-1:0]  mprev_reg, mr_reg;
    logic [QW-1:0]  qq_reg;
    logic signed [TW-1:0] term_reg;
    logic signed [AW-1:0] acc_reg;
    logic [msc_pkg::CNT_W-1:0] vc_reg;
    logic [1:0]     status_reg;

    logic [MW-1:0]  mert_rdata;
    logic [NW-1:0]  lpf_rdata;
    logic [NW-1:0]  prime_rdata;

    logic [CW-1:0]  sl_ext, lim_clamp;
    logic           div_start, div_done;
    logic [SW-1:0]  div_num, div_den, div_quo;
    logic [CW-1:0]  r_ext;
    logic [NW-1:0]  mert_raddr;
    logic [MW:0]    diff;
    logic [MW-1:0]  pf_sum;
    logic           prime_now;
    logic           not_built, side_over;

    msc_div #(.W(SW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        sl_ext = CW'(sieve_limit_reg);
        if (sl_ext < CW'(2))
            lim_clamp = CW'(2);
        else if (sl_ext > CW'(MAX_N))
            lim_clamp = CW'(MAX_N);
        else
            lim_clamp = sl_ext;
    end

    always_comb
    begin
        case (dph_reg)
            2'd0:    begin div_num = m_reg; div_den = l_reg;  end
            2'd1:    begin div_num = n_reg; div_den = l_reg;  end
            2'd2:    begin div_num = m_reg; div_den = qm_reg; end
            default: begin div_num = n_reg; div_den = qn_reg; end
        endcase
    end

    assign div_start  = (op == msc_pkg::OP_DIV_GO);
    assign r_ext      = CW'(r_reg);
    assign mert_raddr = (op == msc_pkg::OP_Q_RD) ? r_ext[NW-1:0] : i_reg;
    assign diff       = {mr_reg[MW-1], mr_reg} - {mprev_reg[MW-1], mprev_reg};
    assign pf_sum     = macc_reg + mert_rdata;
    assign prime_now  = (lpf_rdata == '0);
    assign not_built  = (built_reg == '0);
    assign side_over  = (CW'(a_reg) > CW'(built_reg)) || (CW'(b_reg) > CW'(built_reg));

    assign stat.is_query  = (cmd_reg == msc_pkg::CMD_QUERY);
    assign stat.clr_last  = (c_reg == lim_reg);
    assign stat.i_last    = (i_reg == lim_reg);
    assign stat.j_end     = (j_reg >= pc_reg);
    assign stat.prod_over = (prod_reg > (2*NW)'(lim_reg));
    assign stat.p_is_lpf  = (p_reg == lpfi_reg);
    assign stat.div_done  = div_done;
    assign stat.dph_last  = (dph_reg == 2'd3);
    assign stat.blk_last  = (r_reg == m_reg);
    assign stat.q_special = not_built || side_over || (m_reg == '0);

    // memories: registered reads every cycle, one write port each
    always_ff @(posedge clk)
    begin
        mert_rdata  <= mert_mem[mert_raddr];
        lpf_rdata   <= lpf_mem[i_reg];
        prime_rdata <= prime_mem[j_reg[PAW-1:0]];
        case (op)
            msc_pkg::OP_CLR:    lpf_mem[c_reg] <= '0;
            msc_pkg::OP_INIT0:  mert_mem[0] <= '0;
            msc_pkg::OP_INIT1:  mert_mem[1] <= MW'(1);
            msc_pkg::OP_SV_CHK:
            begin
                if (prime_now)
                    mert_mem[i_reg] <= '1;
            end
            msc_pkg::OP_IN_MARK:
            begin
                if (!stat.prod_over)
                begin
                    lpf_mem[prod_reg[NW-1:0]] <= p_reg;
                    if (stat.p_is_lpf)
                        mert_mem[prod_reg[NW-1:0]] <= '0;
                    else
                        mert_mem[prod_reg[NW-1:0]] <= MW'(-mu_reg);
                end
            end
            msc_pkg::OP_PF_WR:  mert_mem[i_reg] <= pf_sum;
            default:            ;
        endcase
        if ((op == msc_pkg::OP_SV_CHK) && prime_now && (pc_reg < PW'(MAX_PRIMES)))
            prime_mem[pc_reg[PAW-1:0]] <= i_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sieve_limit_reg <= msc_pkg::CFG_W'(65536);
            built_reg       <= '0;
            pc_reg          <= '0;
            dph_reg         <= '0;
            cmd_reg         <= msc_pkg::CMD_BUILD;
        end
        else
        begin
            if (cfg_we)
                sieve_limit_reg <= cfg_data;
            case (op)
                msc_pkg::OP_LOAD:   cmd_reg <= req.cmd;
                msc_pkg::OP_CLR:    pc_reg <= '0;
                msc_pkg::OP_SV_CHK:
                begin
                    if (prime_now && (pc_reg < PW'(MAX_PRIMES)))
                        pc_reg <= pc_reg + PW'(1);
                end
                msc_pkg::OP_FIN_B:  built_reg <= lim_reg;
                msc_pkg::OP_Q_CHK:  dph_reg <= '0;
                msc_pkg::OP_DIV_WAIT:
                begin
                    if (div_done)
                        dph_reg <= dph_reg + 2'd1;
                end
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            msc_pkg::OP_LOAD:
            begin
                lim_reg <= lim_clamp[NW-1:0];
                c_reg   <= '0;
                a_reg   <= req.side_a;
                b_reg   <= req.side_b;
                if (req.side_a < req.side_b)
                begin
                    m_reg <= req.side_a;
                    n_reg <= req.side_b;
                end
                else
                begin
                    m_reg <= req.side_b;
                    n_reg <= req.side_a;
                end
            end
            msc_pkg::OP_CLR:    c_reg <= c_reg + NW'(1);
            msc_pkg::OP_INIT1:  i_reg <= NW'(2);
            msc_pkg::OP_SV_CHK:
            begin
                j_reg <= '0;
                if (prime_now)
                begin
                    mu_reg   <= '1;
                    lpfi_reg <= i_reg;
                end
                else
                begin
                    mu_reg   <= mert_rdata;
                    lpfi_reg <= lpf_rdata;
                end
            end
            msc_pkg::OP_IN_P:
            begin
                p_reg    <= prime_rdata;
                prod_reg <= (2*NW)'(i_reg) * (2*NW)'(prime_rdata);
            end
            msc_pkg::OP_IN_MARK:
            begin
                if (!stat.prod_over && !stat.p_is_lpf)
                    j_reg <= j_reg + PW'(1);
            end
            msc_pkg::OP_SV_NEXT:
            begin
                if (stat.i_last)
                begin
                    i_reg    <= NW'(1);
                    macc_reg <= '0;
                end
                else
                    i_reg <= i_reg + NW'(1);
            end
            msc_pkg::OP_PF_WR:
            begin
                macc_reg <= pf_sum;
                i_reg    <= i_reg + NW'(1);
            end
            msc_pkg::OP_FIN_B:
            begin
                vc_reg     <= '0;
                status_reg <= msc_pkg::ST_OK;
            end
            msc_pkg::OP_Q_CHK:
            begin
                l_reg     <= SW'(1);
                acc_reg   <= AW'(2);
                mprev_reg <= '0;
                if (not_built)
                begin
                    vc_reg     <= '0;
                    status_reg <= msc_pkg::ST_NOT_BUILT;
                end
                else if (side_over)
                begin
                    vc_reg     <= '0;
                    status_reg <= msc_pkg::ST_OVER;
                end
                else
                begin
                    status_reg <= msc_pkg::ST_OK;
                    if (m_reg == '0)
                        vc_reg <= (n_reg == '0) ? '0 : msc_pkg::CNT_W'(1);
                end
            end
            msc_pkg::OP_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (dph_reg)
                        2'd0:    qm_reg <= div_quo;
                        2'd1:    qn_reg <= div_quo;
                        2'd2:    rm_reg <= div_quo;
                        default: r_reg  <= (div_quo < rm_reg) ? div_quo : rm_reg;
                    endcase
                end
            end
            msc_pkg::OP_Q_MUL1:
            begin
                mr_reg <= mert_rdata;
                qq_reg <= QW'(qm_reg) * QW'(qn_reg);
            end
            msc_pkg::OP_Q_MUL2: term_reg <= $signed(diff) * $signed({1'b0, qq_reg});
            msc_pkg::OP_Q_ACC:
            begin
                acc_reg   <= acc_reg + AW'(term_reg);
                mprev_reg <= mr_reg;
                l_reg     <= r_reg + SW'(1);
            end
            msc_pkg::OP_FIN_Q:
            begin
                // clamp to the 33-bit count range
                if (acc_reg[AW-1])
                    vc_reg <= '0;
                else if (acc_reg[AW-2:msc_pkg::CNT_W] != '0)
                    vc_reg <= '1;
                else
                    vc_reg <= acc_reg[msc_pkg::CNT_W-1:0];
            end
            default: ;
        endcase
    end

    assign rsp.visible_count = vc_reg;
    assign rsp.status        = status_reg;

endmodule

// ----- rtl/msc_ctrl.sv -----
module msc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  msc_pkg::dp_stat_t stat,
    output msc_pkg::dp_op_t   op,
    output logic              busy,
    output logic              done
);

    msc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= msc_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msc_pkg::S_IDLE:     if (start) state_next = msc_pkg::S_DISPATCH;
            msc_pkg::S_DISPATCH: state_next = stat.is_query ? msc_pkg::S_Q_CHK : msc_pkg::S_CLR;
            msc_pkg::S_CLR:      if (stat.clr_last) state_next = msc_pkg::S_INIT0;
            msc_pkg::S_INIT0:    state_next = msc_pkg::S_INIT1;
            msc_pkg::S_INIT1:    state_next = msc_pkg::S_SV_RD;
            msc_pkg::S_SV_RD:    state_next = msc_pkg::S_SV_CHK;
            msc_pkg::S_SV_CHK:   state_next = msc_pkg::S_IN_TEST;
            msc_pkg::S_IN_TEST:
                state_next = stat.j_end ? msc_pkg::S_SV_NEXT : msc_pkg::S_IN_P;
            msc_pkg::S_IN_P:     state_next = msc_pkg::S_IN_MARK;
            msc_pkg::S_IN_MARK:
                state_next = (stat.prod_over || stat.p_is_lpf) ? msc_pkg::S_SV_NEXT
                                                               : msc_pkg::S_IN_TEST;
            msc_pkg::S_SV_NEXT:
                state_next = stat.i_last ? msc_pkg::S_PF_RD : msc_pkg::S_SV_RD;
            msc_pkg::S_PF_RD:    state_next = msc_pkg::S_PF_WR;
            msc_pkg::S_PF_WR:
                state_next = stat.i_last ? msc_pkg::S_FIN_B : msc_pkg::S_PF_RD;
            msc_pkg::S_FIN_B:    state_next = msc_pkg::S_RESP;
            msc_pkg::S_Q_CHK:
                state_next = stat.q_special ? msc_pkg::S_RESP : msc_pkg::S_DIV_GO;
            msc_pkg::S_DIV_GO:   state_next = msc_pkg::S_DIV_WAIT;
            msc_pkg::S_DIV_WAIT:
            begin
                if (stat.div_done)
                    state_next = stat.dph_last ? msc_pkg::S_Q_RD : msc_pkg::S_DIV_GO;
            end
            msc_pkg::S_Q_RD:     state_next = msc_pkg::S_Q_MUL1;
            msc_pkg::S_Q_MUL1:   state_next = msc_pkg::S_Q_MUL2;
            msc_pkg::S_Q_MUL2:   state_next = msc_pkg::S_Q_ACC;
            msc_pkg::S_Q_ACC:
                state_next = stat.blk_last ? msc_pkg::S_Q_FIN : msc_pkg::S_DIV_GO;
            msc_pkg::S_Q_FIN:    state_next = msc_pkg::S_RESP;
            msc_pkg::S_RESP:     state_next = msc_pkg::S_IDLE;
            default:             state_next = msc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        op   = msc_pkg::OP_NONE;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            msc_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                    op = msc_pkg::OP_LOAD;
            end
            msc_pkg::S_CLR:      op = msc_pkg::OP_CLR;
            msc_pkg::S_INIT0:    op = msc_pkg::OP_INIT0;
            msc_pkg::S_INIT1:    op = msc_pkg::OP_INIT1;
            msc_pkg::S_SV_RD:    op = msc_pkg::OP_SV_RD;
            msc_pkg::S_SV_CHK:   op = msc_pkg::OP_SV_CHK;
            msc_pkg::S_IN_TEST:  if (!stat.j_end) op = msc_pkg::OP_IN_RD;
            msc_pkg::S_IN_P:     op = msc_pkg::OP_IN_P;
            msc_pkg::S_IN_MARK:  op = msc_pkg::OP_IN_MARK;
            msc_pkg::S_SV_NEXT:  op = msc_pkg::OP_SV_NEXT;
            msc_pkg::S_PF_RD:    op = msc_pkg::OP_PF_RD;
            msc_pkg::S_PF_WR:    op = msc_pkg::OP_PF_WR;
            msc_pkg::S_FIN_B:    op = msc_pkg::OP_FIN_B;
            msc_pkg::S_Q_CHK:    op = msc_pkg::OP_Q_CHK;
            msc_pkg::S_DIV_GO:   op = msc_pkg::OP_DIV_GO;
            msc_pkg::S_DIV_WAIT: op = msc_pkg::OP_DIV_WAIT;
            msc_pkg::S_Q_RD:     op = msc_pkg::OP_Q_RD;
            msc_pkg::S_Q_MUL1:   op = msc_pkg::OP_Q_MUL1;
            msc_pkg::S_Q_MUL2:   op = msc_pkg::OP_Q_MUL2;
            msc_pkg::S_Q_ACC:    op = msc_pkg::OP_Q_ACC;
            msc_pkg::S_Q_FIN:    op = msc_pkg::OP_FIN_Q;
            msc_pkg::S_RESP:     done = 1'b1;
            default:             op = msc_pkg::OP_NONE;
        endcase
    end

endmodule

// ----- rtl/mobius_sieve_coprime_counter.sv -----
// Moebius sieve coprime pair counter.
// Commands enter on req when start is high and busy is low. cmd = build runs
// a linear prime sieve to sieve_limit (clamped to 2..MAX_N), then turns the
// Moebius table into Mertens prefix sums. cmd = query returns 2 plus the
// number of coprime pairs in a side_a by side_b grid (both sides nonzero).
// Every command gives one result on rsp, valid for the single cycle that
// done is high; the receiver cannot hold it off.
// Build: clear the marks up to lim, sieve each integer by trying its products
// with the listed primes (each product is marked or found past the limit),
// then run the prefix pass over the entries.
// Query: each divisor block runs four serial divisions, one table read, two
// multiplies and one accumulate; there are at most 2*(sqrt(m)+sqrt(n))
// blocks.
// Errors and zero sides: done follows the dispatch and check states only.
// busy drops the cycle after done, so the next transfer can follow at once.
// sieve_limit is written on the cfg channel while the block is idle.
// After reset nothing is built: queries return status 1 until a build runs.
module mobius_sieve_coprime_counter #(
    parameter int MAX_N      = 65536,
    parameter int MAX_PRIMES = 8192
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  msc_pkg::req_t             req,
    output logic                      done,
    output msc_pkg::rsp_t             rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [msc_pkg::CFG_W-1:0] cfg_data
);

`include "mobius_sieve_coprime_counter_macros.svh"

    msc_pkg::dp_op_t   op;
    msc_pkg::dp_stat_t stat;

    assign cfg_ready = !busy;

    msc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (op),
        .busy  (busy),
        .done  (done)
    );

    msc_dp #(
        .MAX_N      (MAX_N),
        .MAX_PRIMES (MAX_PRIMES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .req      (req),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .stat     (stat),
        .rsp      (rsp)
    );

    `MSC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `MSC_ASSERT_IMPL(a_done_busy, done, busy)
    `MSC_ASSERT_NEXT(a_done_idle, done, !busy)
    `MSC_ASSERT_IMPL(a_err_zero, done && (rsp.status != msc_pkg::ST_OK), rsp.visible_count == '0)

endmodule

// ----- bench/tb_mobius_sieve_coprime_counter.sv -----
module tb_mobius_sieve_coprime_counter;

    localparam int TABLE_MAX = 65536;
    localparam int PRIME_MAX = 8192;
    localparam longint COUNT_SAT = 64'h1_FFFF_FFFF;

    class coprime_count_board;
        shortint mertens[0:TABLE_MAX];
        bit      composite[0:TABLE_MAX];
        int      primes[0:PRIME_MAX-1];
        int      prime_total;
        int      built_limit;
        int      sieve_limit;
        int      errors;
        msc_pkg::rsp_t pending_answers[$];

        function void reset_state();
            foreach (mertens[k]) mertens[k] = 0;
            built_limit = 0;
            sieve_limit = TABLE_MAX;
            errors = 0;
            pending_answers.delete();
        endfunction

        function void set_limit(logic [msc_pkg::CFG_W-1:0] v);
            sieve_limit = int'(v);
        endfunction

        function void build_mertens();
            int lim, i, j, p, prod;
            lim = sieve_limit;
            if (lim < 2) lim = 2;
            if (lim > TABLE_MAX) lim = TABLE_MAX;
            foreach (composite[k]) composite[k] = 0;
            prime_total = 0;
            mertens[0] = 0;
            mertens[1] = 1;
            for (i = 2; i <= lim; i++) begin
                if (!composite[i]) begin
                    mertens[i] = -1;
                    if (prime_total < PRIME_MAX) begin
                        primes[prime_total] = i;
                        prime_total++;
                    end
                end
                for (j = 0; j < prime_total; j++) begin
                    p = primes[j];
                    if (p > lim / i) break;
                    prod = i * p;
                    composite[prod] = 1;
                    if (i % p != 0) mertens[prod] = -mertens[i];
                    else begin
                        mertens[prod] = 0;
                        break;
                    end
                end
            end
            for (i = 1; i <= lim; i++) mertens[i] = mertens[i] + mertens[i-1];
            built_limit = lim;
        endfunction

        function longint coprime_pairs(longint m, longint n);
            longint acc, l, r, r2, qm, qn;
            if (m == 0 && n == 0) return 0;
            if (m == 0) return 1;
            acc = 2;
            for (l = 1; l <= m; l = r + 1) begin
                qm = m / l;
                qn = n / l;
                r = m / qm;
                r2 = n / qn;
                if (r2 < r) r = r2;
                acc += (longint'(mertens[r]) - longint'(mertens[l-1])) * qm * qn;
            end
            if (acc < 0) return 0;
            if (acc > COUNT_SAT) return COUNT_SAT;
            return acc;
        endfunction

        function void note_command(msc_pkg::req_t r);
            msc_pkg::rsp_t e;
            int a, b;
            e.visible_count = '0;
            e.status = msc_pkg::ST_OK;
            a = int'(r.side_a);
            b = int'(r.side_b);
            if (r.cmd == msc_pkg::CMD_BUILD) build_mertens();
            else if (built_limit == 0) e.status = msc_pkg::ST_NOT_BUILT;
            else if (a > built_limit || b > built_limit) e.status = msc_pkg::ST_OVER;
            else if (a < b)
                e.visible_count = msc_pkg::CNT_W'(coprime_pairs(longint'(a), longint'(b)));
            else
                e.visible_count = msc_pkg::CNT_W'(coprime_pairs(longint'(b), longint'(a)));
            pending_answers.push_back(e);
        endfunction

        function void check_answer(msc_pkg::rsp_t got);
            msc_pkg::rsp_t e;
            if (pending_answers.size() == 0) begin
                $error("result with nothing pending: count %0d status %0d",
                       got.visible_count, got.status);
                errors++;
                return;
            end
            e = pending_answers.pop_front();
            if (got.visible_count !== e.visible_count) begin
                $error("visible_count: expected %0d, got %0d",
                       e.visible_count, got.visible_count);
                errors++;
            end
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    msc_pkg::req_t req;
    logic done;
    msc_pkg::rsp_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [msc_pkg::CFG_W-1:0] cfg_data;

    coprime_count_board board;
    int idle_pct;

    always #5 clk = ~clk;

    mobius_sieve_coprime_counter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always @(posedge clk)
        if (rst_n && done) board.check_answer(rsp);

    task automatic send_cmd(logic c, int a, int b);
        msc_pkg::req_t r;
        int gap;
        r.cmd = c;
        r.side_a = a[msc_pkg::SIDE_W-1:0];
        r.side_b = b[msc_pkg::SIDE_W-1:0];
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        do @(posedge clk); while (busy);
        board.note_command(r);
    endtask

    // hold off new commands until every answer is back
    task automatic drain();
        start <= 1'b0;
        while (board.pending_answers.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_limit(int v);
        cfg_valid <= 1'b1;
        cfg_data <= v[msc_pkg::CFG_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_limit(v[msc_pkg::CFG_W-1:0]);
    endtask

    function automatic int pick_side(int lim);
        if ($urandom_range(0, 9) == 0) return 0;
        return $urandom_range(0, lim);
    endfunction

    initial begin
        int k, sel, lim;
        board = new();
        board.reset_state();
        rst_n <= 1'b0;
        start <= 1'b0;
        req <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        idle_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // queries before any build
        send_cmd(msc_pkg::CMD_QUERY, 0, 0);
        send_cmd(msc_pkg::CMD_QUERY, 5, 3);
        send_cmd(msc_pkg::CMD_QUERY, 131071, 131071);
        drain();
        // limit below range clamps to 2
        write_limit(0);
        send_cmd(msc_pkg::CMD_BUILD, 131071, 77);
        send_cmd(msc_pkg::CMD_QUERY, 0, 0);
        send_cmd(msc_pkg::CMD_QUERY, 0, 2);
        send_cmd(msc_pkg::CMD_QUERY, 2, 0);
        send_cmd(msc_pkg::CMD_QUERY, 2, 2);
        send_cmd(msc_pkg::CMD_QUERY, 3, 1);
        send_cmd(msc_pkg::CMD_QUERY, 1, 1);
        drain();
        write_limit(100);
        send_cmd(msc_pkg::CMD_BUILD, 0, 0);
        send_cmd(msc_pkg::CMD_QUERY, 100, 37);
        send_cmd(msc_pkg::CMD_QUERY, 37, 100);
        send_cmd(msc_pkg::CMD_QUERY, 101, 5);
        send_cmd(msc_pkg::CMD_QUERY, 100, 100);
        drain();
        // limit above range clamps to the full table
        write_limit(131071);
        send_cmd(msc_pkg::CMD_BUILD, 0, 0);
        send_cmd(msc_pkg::CMD_QUERY, 65536, 1);
        send_cmd(msc_pkg::CMD_QUERY, 300, 65536);
        send_cmd(msc_pkg::CMD_QUERY, 131071, 0);
        send_cmd(msc_pkg::CMD_QUERY, 65536, 65537);

        for (k = 0; k < 270; k++) begin
            idle_pct = (k < 90) ? 14 : (k < 180) ? 51 : 0;
            if (k % 45 == 0) begin
                drain();
                sel = $urandom_range(0, 9);
                lim = (sel == 0) ? $urandom_range(0, 1) : $urandom_range(2, 70);
                write_limit(lim);
                send_cmd(msc_pkg::CMD_BUILD, $urandom_range(0, 131071),
                         $urandom_range(0, 131071));
            end
            lim = board.built_limit;
            sel = $urandom_range(0, 99);
            if (sel < 8)
                send_cmd(msc_pkg::CMD_BUILD, $urandom_range(0, 131071),
                         $urandom_range(0, 131071));
            else if (sel < 22)
                send_cmd(msc_pkg::CMD_QUERY, $urandom_range(0, 131071),
                         $urandom_range(0, 131071));
            else
                send_cmd(msc_pkg::CMD_QUERY, pick_side(lim), pick_side(lim));
        end

        drain();
        repeat (50) @(posedge clk);
        if (board.errors == 0 && board.pending_answers.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #200000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
